// ===== hdl/crc16sec_pkg.sv =====
`timescale 1ns / 1ps

package crc16sec_pkg;

	localparam int ENTRY_BYTES = 64;

	localparam int POS_W = 6;
	localparam logic [15:0] CRC_START = 16'hFFFF;
	localparam logic [7:0] TERM_BYTE = 8'h00;
	localparam logic [1:0] TAIL_COUNT = 2'd2;
	localparam logic [POS_W-1:0] POS_MAX = 6'd63;
	// last position that still leaves room for the two crc bytes, plus one
	localparam logic [POS_W:0] TEXT_LIMIT = 7'(ENTRY_BYTES - 2);

	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 16;

	typedef logic [POS_W-1:0] pos_t;

	// crc-16 ccitt-false, one byte, msb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] x;
		x = crc[15:8] ^ b;
		x = x ^ {4'h0, x[7:4]};
		return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
	endfunction

endpackage

// ===== hdl/crc16_string_entry_checker.sv =====
`timescale 1ns / 1ps
// each result is registered and appears in the cycle after its input transfer
// throughput: one byte per cycle; the crc update, flags and verdict sit between
// the entry state registers and the result register; while the result register
// is full, input ready follows output ready in the same cycle
// reset: arst_n clears the entry state (crc to 0xffff) and empties the result register
// the entry state is also cleared after every byte marked last

module crc16_string_entry_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [crc16sec_pkg::S_DATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic                               s_axis_tlast,  // last
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [crc16sec_pkg::M_DATA_W-1:0]  m_axis_tdata,  // [7:0] text_byte, [8] entry_ok,
	                                                           // [14:9] text_length, [15] zero
	output logic                               m_axis_tuser,  // [0] text_valid
	output logic                               m_axis_tlast   // entry_done
);
	import crc16sec_pkg::*;

	logic [15:0] crc_q;
	pos_t        pos_q;
	logic        term_q;
	logic [1:0]  tail_q;
	logic        first_nz_q;
	pos_t        tidx_q;

	logic [15:0] crc_n;
	pos_t        pos_n;
	logic        term_n;
	logic [1:0]  tail_n;
	logic        first_nz_n;
	pos_t        tidx_n;
	logic        text;
	logic        ok;
	logic [7:0]  b;
	logic        in_xfer;

	logic        valid_s1;
	logic [7:0]  text_byte_s1;
	logic        text_valid_s1;
	logic        done_s1;
	logic        ok_s1;
	pos_t        len_s1;

	assign b = s_axis_tdata[7:0];
	assign s_axis_tready = !valid_s1 || m_axis_tready;
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	always_comb begin
		crc_n = crc_q;
		term_n = term_q;
		tail_n = tail_q;
		tidx_n = tidx_q;
		text = 1'b0;
		first_nz_n = first_nz_q || (pos_q == '0 && b != TERM_BYTE);
		if (!term_q) begin
			crc_n = crc_byte(crc_q, b);
			if (b == TERM_BYTE) begin
				term_n = 1'b1;
				tidx_n = pos_q;
			end else begin
				text = {1'b0, pos_q} < TEXT_LIMIT;
			end
		end else if (tail_q < TAIL_COUNT) begin
			crc_n = crc_byte(crc_q, b);
			tail_n = tail_q + 2'd1;
		end
		pos_n = (pos_q < POS_MAX) ? pos_q + 1'b1 : pos_q;
		ok = first_nz_n && term_n && ({1'b0, tidx_n} < TEXT_LIMIT) &&
		     tail_n == TAIL_COUNT && crc_n == 16'h0000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_START;
			pos_q <= '0;
			term_q <= 1'b0;
			tail_q <= '0;
			first_nz_q <= 1'b0;
			tidx_q <= '0;
		end else if (in_xfer) begin
			if (s_axis_tlast) begin
				crc_q <= CRC_START;
				pos_q <= '0;
				term_q <= 1'b0;
				tail_q <= '0;
				first_nz_q <= 1'b0;
				tidx_q <= '0;
			end else begin
				crc_q <= crc_n;
				pos_q <= pos_n;
				term_q <= term_n;
				tail_q <= tail_n;
				first_nz_q <= first_nz_n;
				tidx_q <= tidx_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			text_byte_s1 <= text ? b : 8'h00;
			text_valid_s1 <= text;
			done_s1 <= s_axis_tlast;
			ok_s1 <= s_axis_tlast && ok;
			len_s1 <= (s_axis_tlast && ok) ? tidx_n : '0;
		end
	end

	assign m_axis_tvalid = valid_s1;
	assign m_axis_tdata = {1'b0, len_s1, ok_s1, text_byte_s1};
	assign m_axis_tuser = text_valid_s1;
	assign m_axis_tlast = done_s1;

endmodule

// ===== hdl/crc16sec_checker.sv =====
`timescale 1ns / 1ps

module crc16sec_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [crc16sec_pkg::M_DATA_W-1:0]  m_axis_tdata,
	input logic                               m_axis_tuser,
	input logic                               m_axis_tlast
);
	import crc16sec_pkg::*;

	// a stalled result stays on offer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// every input transfer yields a result in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("no result after input transfer");

	// a verdict only comes with the entry's final byte
	a_ok_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tlast)
		else $error("entry_ok outside entry_done");

	// a passing entry has a nonzero length, a failing one reports zero
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[8] == (m_axis_tdata[14:9] != '0)))
		else $error("text_length inconsistent with entry_ok");

	// non-text bytes go out as zero
	a_text: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
		else $error("text_byte set without text_valid");

endmodule

bind crc16_string_entry_checker crc16sec_checker u_crc16sec_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
